>>> rtl/rcbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcbp_pkg;

   // Request operations
   localparam logic [1:0] OP_INIT   = 2'd0;
   localparam logic [1:0] OP_ALLOC  = 2'd1;
   localparam logic [1:0] OP_REF    = 2'd2;
   localparam logic [1:0] OP_UNREF  = 2'd3;

   // Response status codes
   localparam logic [1:0] STS_DONE        = 2'd0;
   localparam logic [1:0] STS_EXHAUSTED   = 2'd1;
   localparam logic [1:0] STS_DOUBLE_FREE = 2'd2;
   localparam logic [1:0] STS_BAD_INDEX   = 2'd3;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_STREAMING_ENTRIES = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROL_ENTRIES   = 4'd1;

   // Channel widths
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 112;

   // Hard ceiling on the slots of one pool
   localparam logic [6:0] SLOT_CAP = 7'd64;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;    // latch request, launch memory reads
      logic exec;       // apply the operation, load the response
      logic sweep;      // write one entry of the rebuild pass
      logic boot_next;  // switch the reset rebuild to the control pool
   } rcbp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic init_op;
      logic sweep_last;
      logic sweep_pool;
      logic rsp_free;
   } rcbp_sts_type;

endpackage

`default_nettype wire

>>> rtl/refcounted_buffer_pool.sv
`timescale 1ns / 1ps
`default_nettype none

// Reference-counted buffer pool with two pools, streaming (tuser 0) and control
// (tuser 1), each a LIFO free list of slot numbers plus a 16-bit reference
// count and a free mark per slot, both kept in registered-read RAMs. Allocate,
// add reference and drop reference each start in the accept cycle, which
// launches the RAM reads; the execute state, once the response register is
// free, does the read-modify-write and loads the response register; the
// response may wait there while the next request is accepted. Init loads its
// response in the execute state, then a rebuild pass writes one slot per cycle
// before the next request is taken. After reset a rebuild pass runs over both
// pools with req_tready low; configuration writes are accepted at all times
// and take effect at the next init of their pool.
module refcounted_buffer_pool #(
   parameter int unsigned MAX_SLOTS = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Requests
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [1:0] operation, [7:2] slot_index
   input  wire logic [rcbp_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [0] pool_select
   input  wire logic                                 req_tuser,
   // Responses
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [1:0] status, [7:2] granted_slot, [23:8] ref_after, [30:24] slots_in_use,
   // [37:31] peak_in_use, [44:38] free_slots, [76:45] failed_allocs,
   // [108:77] double_frees, [111:109] zero
   output logic      [rcbp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Configuration writes
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [rcbp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [rcbp_pkg::CSR_DATA_W-1:0]      csr_data
);

   import rcbp_pkg::*;

   rcbp_cmd_type cmd;
   rcbp_sts_type sts;

   // Registers are plain flops: always ready
   assign csr_ready = 1'b1;

   // Sequence accept, execute and rebuild passes
   rcbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Hold pool state, memories and the response register
   rcbp_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire

>>> rtl/rcbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rcbp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/rcbp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rcbp_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire rcbp_pkg::rcbp_sts_type sts,
   output rcbp_pkg::rcbp_cmd_type     cmd
);

   import rcbp_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       boot_ff, boot_in;

   always_comb begin
      state_in   = state_ff;
      boot_in    = boot_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.rsp_free) begin
               cmd.exec = 1'b1;
               state_in = sts.init_op ? ST_SWEEP : ST_IDLE;
            end
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               if (boot_ff && !sts.sweep_pool) begin
                  cmd.boot_next = 1'b1;
               end else begin
                  boot_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         boot_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         boot_ff  <= boot_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/rcbp_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rcbp_dp #(
   parameter int unsigned MAX_SLOTS = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [rcbp_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic                                 req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [rcbp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                                 csr_valid,
   input  wire logic [rcbp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [rcbp_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire rcbp_pkg::rcbp_cmd_type               cmd,
   output rcbp_pkg::rcbp_sts_type                    sts
);

   import rcbp_pkg::*;

   localparam int unsigned SW = $clog2(MAX_SLOTS);
   localparam int unsigned AW = SW + 1;
   localparam int unsigned CW = SW + 7;
   localparam int unsigned EW = 17;
   localparam logic [6:0]  LIM = (MAX_SLOTS < 64) ? 7'(MAX_SLOTS) : 7'd64;
   localparam logic [SW-1:0] LAST_IDX = SW'(MAX_SLOTS - 1);
   localparam logic [CW-1:0] MAX_DEPTH = CW'(MAX_SLOTS);

   function automatic logic [6:0] sized(input logic [6:0] v);
      logic [6:0] r;
      if (v == 7'd0) begin
         r = 7'd1;
      end else if (v > LIM) begin
         r = LIM;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [SW-1:0] to_idx(input logic [6:0] v);
      logic [CW-1:0] t;
      t = CW'(v);
      return t[SW-1:0];
   endfunction

   // Configuration and per-pool counters
   logic [6:0]  cfg_size_ff [2];
   logic [6:0]  pool_size_ff [2], pool_size_in [2];
   logic [6:0]  depth_ff [2],     depth_in [2];
   logic [6:0]  inuse_ff [2],     inuse_in [2];
   logic [6:0]  peak_ff [2],      peak_in [2];
   logic [31:0] fail_ff [2],      fail_in [2];
   logic [31:0] dbl_ff [2],       dbl_in [2];

   // Captured request
   logic [1:0] op_ff;
   logic       pool_ff;
   logic [5:0] slot_ff;

   // Rebuild pass
   logic          sweep_pool_ff, sweep_pool_in;
   logic [SW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic [CW-1:0] sweep_wide;

   // Response register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // Memory ports
   logic          stk_wr_en, ent_wr_en;
   logic [AW-1:0] stk_wr_addr, ent_wr_addr, stk_rd_addr, ent_rd_addr;
   logic [5:0]    stk_wr_data, stk_rd_data;
   logic [EW-1:0] ent_wr_data, ent_rd_data;

   // Operation results
   logic [1:0]  res_status;
   logic [5:0]  res_granted;
   logic [15:0] res_ref;
   logic [6:0]  depth_m1;
   logic [15:0] cnt_dec;
   logic        in_range;

   logic [1:0] req_op;
   logic [5:0] req_slot;
   logic [6:0] req_depth_m1;

   assign req_op       = req_tdata[1:0];
   assign req_slot     = req_tdata[7:2];
   assign req_depth_m1 = depth_ff[req_tuser] - 7'd1;

   // Reads launch in the accept cycle; data is ready in the execute cycle
   assign stk_rd_addr = {req_tuser, to_idx(req_depth_m1)};
   assign ent_rd_addr = {req_tuser, to_idx({1'b0, req_slot})};

   assign depth_m1   = depth_ff[pool_ff] - 7'd1;
   assign cnt_dec    = ent_rd_data[15:0] - 16'd1;
   assign in_range   = ({1'b0, slot_ff} < pool_size_ff[pool_ff]);
   assign sweep_wide = CW'(sweep_cnt_ff);

   rcbp_ram #(.WIDTH(6), .DEPTH(2 ** AW)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   // Entry word: mark in the top bit, reference count below
   rcbp_ram #(.WIDTH(EW), .DEPTH(2 ** AW)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   always_comb begin
      pool_size_in  = pool_size_ff;
      depth_in      = depth_ff;
      inuse_in      = inuse_ff;
      peak_in       = peak_ff;
      fail_in       = fail_ff;
      dbl_in        = dbl_ff;
      sweep_pool_in = sweep_pool_ff;
      sweep_cnt_in  = sweep_cnt_ff;

      res_status  = STS_DONE;
      res_granted = slot_ff;
      res_ref     = '0;

      // Rebuild pass writes by default
      stk_wr_en   = cmd.sweep;
      stk_wr_addr = {sweep_pool_ff, sweep_cnt_ff};
      stk_wr_data = (sweep_wide < CW'(pool_size_ff[sweep_pool_ff])) ? sweep_wide[5:0] : 6'd0;
      ent_wr_en   = cmd.sweep;
      ent_wr_addr = {sweep_pool_ff, sweep_cnt_ff};
      ent_wr_data = {1'b1, 16'd0};

      if (cmd.boot_next) begin
         sweep_pool_in = 1'b1;
         sweep_cnt_in  = '0;
      end else if (cmd.sweep) begin
         sweep_cnt_in = sweep_cnt_ff + SW'(1);
      end

      if (cmd.exec) begin
         unique case (op_ff)
            OP_INIT: begin
               pool_size_in[pool_ff] = sized(cfg_size_ff[pool_ff]);
               depth_in[pool_ff]     = sized(cfg_size_ff[pool_ff]);
               inuse_in[pool_ff]     = '0;
               peak_in[pool_ff]      = '0;
               fail_in[pool_ff]      = '0;
               dbl_in[pool_ff]       = '0;
               sweep_pool_in         = pool_ff;
               sweep_cnt_in          = '0;
            end
            OP_ALLOC: begin
               if (depth_ff[pool_ff] == 7'd0) begin
                  fail_in[pool_ff] = fail_ff[pool_ff] + 32'd1;
                  res_status       = STS_EXHAUSTED;
               end else begin
                  depth_in[pool_ff] = depth_m1;
                  res_granted       = stk_rd_data;
                  res_ref           = 16'd1;
                  ent_wr_en         = 1'b1;
                  ent_wr_addr       = {pool_ff, to_idx({1'b0, stk_rd_data})};
                  ent_wr_data       = {1'b0, 16'd1};
                  if (inuse_ff[pool_ff] < SLOT_CAP) begin
                     inuse_in[pool_ff] = inuse_ff[pool_ff] + 7'd1;
                  end
                  if (inuse_in[pool_ff] > peak_ff[pool_ff]) begin
                     peak_in[pool_ff] = inuse_in[pool_ff];
                  end
               end
            end
            OP_REF: begin
               if (!in_range) begin
                  res_status = STS_BAD_INDEX;
               end else begin
                  res_ref     = ent_rd_data[15:0] + 16'd1;
                  ent_wr_en   = 1'b1;
                  ent_wr_addr = {pool_ff, to_idx({1'b0, slot_ff})};
                  ent_wr_data = {ent_rd_data[16], res_ref};
               end
            end
            OP_UNREF: begin
               if (!in_range) begin
                  res_status = STS_BAD_INDEX;
               end else begin
                  res_ref     = cnt_dec;
                  ent_wr_en   = 1'b1;
                  ent_wr_addr = {pool_ff, to_idx({1'b0, slot_ff})};
                  ent_wr_data = {ent_rd_data[16], cnt_dec};
                  if (cnt_dec == 16'd0) begin
                     if (ent_rd_data[16]) begin
                        dbl_in[pool_ff] = dbl_ff[pool_ff] + 32'd1;
                        res_status      = STS_DOUBLE_FREE;
                     end else if (CW'(depth_ff[pool_ff]) < MAX_DEPTH) begin
                        // Push the slot back and mark it free
                        ent_wr_data       = {1'b1, cnt_dec};
                        stk_wr_en         = 1'b1;
                        stk_wr_addr       = {pool_ff, to_idx(depth_ff[pool_ff])};
                        stk_wr_data       = slot_ff;
                        depth_in[pool_ff] = depth_ff[pool_ff] + 7'd1;
                     end
                     if (inuse_ff[pool_ff] != 7'd0) begin
                        inuse_in[pool_ff] = inuse_ff[pool_ff] - 7'd1;
                     end
                  end
               end
            end
            default: begin
               res_status = STS_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         pool_ff <= req_tuser;
         slot_ff <= req_slot;
      end
      if (cmd.exec) begin
         rsp_data_ff <= {3'd0, dbl_in[pool_ff], fail_in[pool_ff], depth_in[pool_ff],
                         peak_in[pool_ff], inuse_in[pool_ff], res_ref, res_granted,
                         res_status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_size_ff[0]  <= 7'd64;
         cfg_size_ff[1]  <= 7'd16;
         pool_size_ff[0] <= sized(7'd64);
         pool_size_ff[1] <= sized(7'd16);
         depth_ff[0]     <= sized(7'd64);
         depth_ff[1]     <= sized(7'd16);
         inuse_ff        <= '{default: '0};
         peak_ff         <= '{default: '0};
         fail_ff         <= '{default: '0};
         dbl_ff          <= '{default: '0};
         sweep_pool_ff   <= 1'b0;
         sweep_cnt_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_STREAMING_ENTRIES: cfg_size_ff[0] <= csr_data;
               CSR_CONTROL_ENTRIES:   cfg_size_ff[1] <= csr_data;
               default: begin
               end
            endcase
         end
         pool_size_ff  <= pool_size_in;
         depth_ff      <= depth_in;
         inuse_ff      <= inuse_in;
         peak_ff       <= peak_in;
         fail_ff       <= fail_in;
         dbl_ff        <= dbl_in;
         sweep_pool_ff <= sweep_pool_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         if (cmd.exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign sts.init_op    = (op_ff == OP_INIT);
   assign sts.sweep_last = (sweep_cnt_ff == LAST_IDX);
   assign sts.sweep_pool = sweep_pool_ff;
   assign sts.rsp_free   = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire
